// File: rtl/core/multi_channel_debounce_change_detect_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-channel debouncer
// Clocked on clk, disabled while rst_n is low; report by $error.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_DEBOUNCE_CHANGE_DETECT_ASSERT_SVH
`define MULTI_CHANNEL_DEBOUNCE_CHANGE_DETECT_ASSERT_SVH

// Same-cycle implication
`define MCDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MCDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mcdc_pkg.sv
// ---------------------------------------------------------------------------
// mcdc_pkg
// Shared constants, codes and transaction types of the debouncer.
// ---------------------------------------------------------------------------
package mcdc_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int VALUE_W   = 32;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [SLOT_W:0]    SLOT_LIMIT   = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [COUNT_W-1:0] DEBOUNCE_MIN = 8'd2;

    // request codes
    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_PRELOAD = 2'd1;
    localparam logic [1:0] REQ_FORCE   = 2'd2;

    // register word indexes
    localparam logic [0:0] REG_DEBOUNCE_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      transition_allowed;
        logic [TIME_W-1:0]         timestamp;
    } req_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]         event_slot;
        logic signed [VALUE_W-1:0] prev_value;
        logic signed [VALUE_W-1:0] curr_value;
        logic [TIME_W-1:0]         event_time;
    } evt_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] confirmed;
        logic [VALUE_W-1:0] candidate;
        logic [COUNT_W-1:0] count;
    } slot_state_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        slot_state_t       data;
    } state_wr_t;

    typedef struct packed {
        logic wr_en;
        logic ev;
    } upd_ctrl_t;

endpackage

// File: rtl/core/multi_channel_debounce_change_detect.sv
// ---------------------------------------------------------------------------
// multi_channel_debounce_change_detect
// Top level: request register, slot state file, update logic, event register
// and the APB register port.
// ---------------------------------------------------------------------------
// Debounces up to 32 channel slots and reports confirmed value changes. One
// request transaction is accepted per clock cycle, back to back, while
// req_stall is low. An accepted request is held in the request register; one
// read-modify-write of the addressed slot then loads any event it makes into
// the event register. Rate is set by that single read-modify-write of the
// slot state file (combinational read, registered write), which reads and
// writes one slot per cycle while requests advance, so consecutive requests
// to the same slot see each other's updates without extra delay.
// A request that makes an event waits in the request register only while a
// stalled event still sits in the event register. Sample requests with
// transition_allowed low are dropped. With debounce_threshold at 2 or more a
// value must be sampled that many times in a row before it is confirmed; the
// match count saturates at 255. Preload sets a slot's value silently; force
// emits the current value with old and new equal. Slot state resets to zero
// through per-slot valid bits, so there is no clearing pass after reset.
// Write debounce_threshold (byte address 0) only while the block is idle.
// ---------------------------------------------------------------------------
module multi_channel_debounce_change_detect
    import mcdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  req_item_t         req_data,

    // event channel
    output logic              evt_valid,
    input  logic              evt_stall,
    output evt_item_t         evt_data,

    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic               req_valid_reg;
    req_item_t          req_item_reg;
    logic               evt_valid_reg;
    evt_item_t          evt_item_reg;
    logic [COUNT_W-1:0] threshold_reg;

    slot_state_t        cur_state;
    slot_state_t        nxt_state;
    state_wr_t          state_wr;
    upd_ctrl_t          upd_ctrl;
    evt_item_t          upd_evt;

    logic               out_free;
    logic               fire;
    logic               cfg_wr;

    // ---- register port ----------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_DEBOUNCE_THRESHOLD))
        begin
            threshold_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Return the threshold at its word; read zero elsewhere
    assign prdata = (paddr[2] == REG_DEBOUNCE_THRESHOLD) ?
                    DATA_W'(threshold_reg) : '0;

    // ---- handshake control ------------------------------------------------
    // The event register is free when empty or being drained this cycle.
    // A held request advances unless it makes an event that cannot land.
    assign out_free  = !evt_valid_reg || !evt_stall;
    assign fire      = req_valid_reg && (!upd_ctrl.ev || out_free);
    assign req_stall = req_valid_reg && !fire;

    // ---- request register -------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_item_reg <= req_data;
        end
    end

    // ---- slot state and update --------------------------------------------
    mcdc_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (req_item_reg.slot),
        .rd_data (cur_state),
        .wr      (state_wr)
    );

    mcdc_update u_update (
        .item      (req_item_reg),
        .cur       (cur_state),
        .threshold (threshold_reg),
        .ctrl      (upd_ctrl),
        .nxt       (nxt_state),
        .evt       (upd_evt)
    );

    // Commit the slot write only when the request actually advances
    assign state_wr.en   = fire && upd_ctrl.wr_en;
    assign state_wr.slot = req_item_reg.slot;
    assign state_wr.data = nxt_state;

    // ---- event register ---------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (fire && upd_ctrl.ev)
        begin
            evt_valid_reg <= 1'b1;
        end
        else if (!evt_stall)
        begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && upd_ctrl.ev)
        begin
            evt_item_reg <= upd_evt;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_item_reg;

endmodule

// File: rtl/core/mcdc_state.sv
// ---------------------------------------------------------------------------
// mcdc_state
// Per-slot state file: confirmed value, candidate value and match count,
// with a valid bit per slot so that an unwritten slot reads as zero.
// ---------------------------------------------------------------------------
module mcdc_state
    import mcdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_slot,
    output slot_state_t       rd_data,
    input  state_wr_t         wr
);

    slot_state_t            slot_state_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   slot_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (wr.en)
        begin
            slot_valid_reg[wr.slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_state_reg[wr.slot] <= wr.data;
        end
    end

    // untouched slots read as the reset value
    assign rd_data = slot_valid_reg[rd_slot] ? slot_state_reg[rd_slot] : '0;

endmodule

// File: rtl/core/mcdc_update.sv
// ---------------------------------------------------------------------------
// mcdc_update
// Next-state and event logic for one request against one slot's state.
// ---------------------------------------------------------------------------
module mcdc_update
    import mcdc_pkg::*;
(
    input  req_item_t          item,
    input  slot_state_t        cur,
    input  logic [COUNT_W-1:0] threshold,
    output upd_ctrl_t          ctrl,
    output slot_state_t        nxt,
    output evt_item_t          evt
);

    logic               slot_ok;
    logic               debounce_on;
    logic               same_cand;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_new;
    logic               confirm;
    logic               changed;

    assign slot_ok     = (SLOT_W + 1)'(item.slot) < SLOT_LIMIT;
    assign debounce_on = threshold >= DEBOUNCE_MIN;
    assign same_cand   = item.sample_value == cur.candidate;
    assign count_inc   = (cur.count == COUNT_MAX) ? cur.count : cur.count + COUNT_W'(1);
    assign count_new   = same_cand ? count_inc : COUNT_W'(1);
    assign confirm     = !debounce_on || (count_new >= threshold);
    assign changed     = item.sample_value != cur.confirmed;

    always_comb
    begin
        ctrl            = '0;
        nxt             = cur;
        evt.event_slot  = item.slot;
        evt.prev_value  = cur.confirmed;
        evt.curr_value  = item.sample_value;
        evt.event_time  = item.timestamp;

        if (slot_ok)
        begin
            case (item.req_type)
                REQ_SAMPLE:
                begin
                    if (item.transition_allowed)
                    begin
                        if (debounce_on)
                        begin
                            ctrl.wr_en    = 1'b1;
                            nxt.candidate = item.sample_value;
                            nxt.count     = count_new;
                        end
                        if (confirm && changed)
                        begin
                            ctrl.wr_en    = 1'b1;
                            ctrl.ev       = 1'b1;
                            nxt.confirmed = item.sample_value;
                        end
                    end
                end
                REQ_PRELOAD:
                begin
                    ctrl.wr_en    = 1'b1;
                    nxt.confirmed = item.sample_value;
                    nxt.candidate = item.sample_value;
                    nxt.count     = '0;
                end
                REQ_FORCE:
                begin
                    ctrl.ev        = 1'b1;
                    evt.curr_value = cur.confirmed;
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/multi_channel_debounce_change_detect_checker.sv
// ---------------------------------------------------------------------------
// multi_channel_debounce_change_detect_checker
// Port-level checks of the debouncer, bound to the top level.
// ---------------------------------------------------------------------------
`include "multi_channel_debounce_change_detect_assert.svh"

module multi_channel_debounce_change_detect_checker
    import mcdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  req_item_t         req_data,
    input  logic              evt_valid,
    input  logic              evt_stall,
    input  evt_item_t         evt_data
);

    logic      req_acc;
    logic      evt_free;
    logic      evt_held;
    logic      force_acc;
    logic      preload_acc;
    logic      force_hit;
    req_item_t req_d1_reg;
    req_item_t req_d2_reg;

    assign req_acc     = req_valid && !req_stall;
    assign evt_free    = !evt_valid || !evt_stall;
    assign evt_held    = evt_valid && evt_stall;
    assign force_acc   = req_acc && (req_data.req_type == REQ_FORCE);
    assign preload_acc = req_acc && (req_data.req_type == REQ_PRELOAD);

    // delay the request payload through req_d1_reg and req_d2_reg to line up with its event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_d1_reg <= '0;
            req_d2_reg <= '0;
        end
        else
        begin
            req_d1_reg <= req_data;
            req_d2_reg <= req_d1_reg;
        end
    end

    assign force_hit = evt_valid
                       && (evt_data.event_time == req_d2_reg.timestamp)
                       && (evt_data.event_slot == req_d2_reg.slot)
                       && (evt_data.prev_value == evt_data.curr_value);

    // hold a stalled event
    `MCDC_ASSERT_NEXT(a_evt_hold, evt_held, evt_valid, "event dropped while stalled")

    `MCDC_ASSERT_NEXT(a_evt_stable, evt_held, $stable(evt_data), "stalled event changed")

    // a force reaches the event port, via the request and event registers, when the port is free
    `MCDC_ASSERT_NEXT(a_force_emit, force_acc ##1 evt_free, force_hit, "force gave no event")

    // a preload never produces an event
    `MCDC_ASSERT_NEXT(a_preload_quiet, preload_acc ##1 !evt_valid, !evt_valid, "preload evented")

endmodule

bind multi_channel_debounce_change_detect multi_channel_debounce_change_detect_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data)
);
